[design/i2cms_pkg.sv]
// Shared types, constants and helpers for the I2C master bit sequencer.
// Depends on nothing; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package i2cms_pkg;

   localparam int unsigned FuncWidth     = 3;
   localparam int unsigned DataWidth     = 8;
   localparam int unsigned TickWidth     = 8;
   localparam int unsigned BitCntWidth   = 4;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [BitCntWidth-1:0] BitsPerByte = BitCntWidth'(8);

   // Register reset values
   localparam logic [TickWidth-1:0] StartStopReset  = TickWidth'(4);
   localparam logic [TickWidth-1:0] BitPhaseReset   = TickWidth'(2);
   localparam logic [TickWidth-1:0] AckTimeoutReset = TickWidth'(250);

   typedef enum logic [FuncWidth-1:0] {
      FUNC_TICK  = 3'd0,
      FUNC_START = 3'd1,
      FUNC_STOP  = 3'd2,
      FUNC_WRITE = 3'd3,
      FUNC_READ  = 3'd4
   } func_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_START_STOP  = 2'd0,
      CSR_BIT_PHASE   = 2'd1,
      CSR_ACK_TIMEOUT = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_ST_A    = 4'd1,
      PH_ST_B    = 4'd2,
      PH_SP_A    = 4'd3,
      PH_SP_B    = 4'd4,
      PH_WR_DATA = 4'd5,
      PH_WR_HIGH = 4'd6,
      PH_WR_LOW  = 4'd7,
      PH_AK_REL  = 4'd8,
      PH_AK_CLK  = 4'd9,
      PH_AK_POLL = 4'd10,
      PH_RD_LOW  = 4'd11,
      PH_RD_HIGH = 4'd12,
      PH_RA_SET  = 4'd13,
      PH_RA_HIGH = 4'd14
   } phase_type;

   // Remaining-tick load for a segment of dur ticks; zero acts as one tick.
   function automatic logic [TickWidth-1:0] load_count(input logic [TickWidth-1:0] dur);
      return (dur == '0) ? '0 : dur - TickWidth'(1);
   endfunction

endpackage

[design/i2cms_if.sv]
// Valid/ready channel interfaces: tick requests, bus results, register writes.
// Depends on i2cms_pkg for field widths.
`timescale 1ns / 1ps

interface i2cms_req_if;
   logic                               valid;
   logic                               ready;
   logic [i2cms_pkg::FuncWidth-1:0]    func;
   logic [i2cms_pkg::DataWidth-1:0]    tx_byte;
   logic                               send_ack;
   logic                               sda_in;

   modport source (output valid, func, tx_byte, send_ack, sda_in, input ready);
   modport sink   (input valid, func, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cms_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               scl_out;
   logic                               sda_out;
   logic                               busy_res;
   logic                               done_res;
   logic [i2cms_pkg::DataWidth-1:0]    rx_byte;
   logic                               no_ack;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, no_ack,
                   input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, no_ack,
                   output ready);
endinterface

interface i2cms_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [i2cms_pkg::CsrIndexWidth-1:0]   index;
   logic [i2cms_pkg::TickWidth-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/i2c_master_bit_sequencer.sv]
// The result for a tick request is in the output register in the cycle after acceptance.
// Throughput: one tick request per cycle; the output register lets the next request in
//    whenever it is empty or being drained in the same cycle.
// Reset (synchronous, active high): sequencer idle, SCL/SDA released, counters and
//    read data cleared, timing registers back to 4 / 2 / 250, no result pending.
// Depends on i2cms_pkg and the channel interfaces in i2cms_if.sv.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer (
   input  logic        clock,
   input  logic        reset,
   i2cms_req_if.sink   req_chan,
   i2cms_rsp_if.source rsp_chan,
   i2cms_csr_if.sink   csr_chan
);

   // ---- timing registers -------------------------------------------------
   logic [i2cms_pkg::TickWidth-1:0] start_stop_ff;
   logic [i2cms_pkg::TickWidth-1:0] bit_phase_ff;
   logic [i2cms_pkg::TickWidth-1:0] ack_timeout_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_stop_ff  <= i2cms_pkg::StartStopReset;
         bit_phase_ff   <= i2cms_pkg::BitPhaseReset;
         ack_timeout_ff <= i2cms_pkg::AckTimeoutReset;
      end else if (csr_chan.valid) begin
         unique case (i2cms_pkg::csr_index_type'(csr_chan.index))
            i2cms_pkg::CSR_START_STOP:  start_stop_ff  <= csr_chan.data;
            i2cms_pkg::CSR_BIT_PHASE:   bit_phase_ff   <= csr_chan.data;
            i2cms_pkg::CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_chan.data;
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   // ---- sequencer state --------------------------------------------------
   i2cms_pkg::phase_type              phase_ff, phase_in;
   logic [i2cms_pkg::TickWidth-1:0]   tick_ff, tick_in;
   logic [i2cms_pkg::BitCntWidth-1:0] bit_ff, bit_in;
   logic [i2cms_pkg::DataWidth-1:0]   shift_ff, shift_in;
   logic                              scl_ff, scl_in;
   logic                              sda_ff, sda_in;
   logic                              ack_choice_ff, ack_choice_in;
   logic                              ack_failed_ff, ack_failed_in;
   logic [i2cms_pkg::DataWidth-1:0]   rx_hold_ff, rx_hold_in;
   logic                              done_in;

   // output register
   logic                              rsp_valid_ff;
   logic                              rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff;
   logic                              rsp_no_ack_ff;
   logic [i2cms_pkg::DataWidth-1:0]   rsp_rx_ff;

   logic                              req_take;

   // A request moves in whenever the result slot is free or leaving this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   // ---- next-state logic: one bus tick per request -----------------------
   always_comb begin
      logic [i2cms_pkg::TickWidth-1:0]   poll_tick;
      logic [i2cms_pkg::BitCntWidth-1:0] bit_inc;

      phase_in      = phase_ff;
      tick_in       = tick_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      ack_choice_in = ack_choice_ff;
      ack_failed_in = ack_failed_ff;
      rx_hold_in    = rx_hold_ff;
      done_in       = 1'b0;

      // ack polling restarts its count when entered from the clock setup tick
      poll_tick = (phase_ff == i2cms_pkg::PH_AK_CLK) ? '0 : tick_ff;
      bit_inc   = bit_ff + i2cms_pkg::BitCntWidth'(1);

      if (phase_ff == i2cms_pkg::PH_IDLE) begin
         unique case (i2cms_pkg::func_type'(req_chan.func))
            i2cms_pkg::FUNC_START: begin
               phase_in = i2cms_pkg::PH_ST_A;
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               tick_in  = i2cms_pkg::load_count(start_stop_ff);
            end
            i2cms_pkg::FUNC_STOP: begin
               phase_in = i2cms_pkg::PH_SP_A;
               scl_in   = 1'b0;
               sda_in   = 1'b0;
               tick_in  = i2cms_pkg::load_count(start_stop_ff);
            end
            i2cms_pkg::FUNC_WRITE: begin
               // first data bit goes straight out, MSB first
               ack_failed_in = 1'b0;
               bit_in        = '0;
               shift_in      = {req_chan.tx_byte[i2cms_pkg::DataWidth-2:0], 1'b0};
               phase_in      = i2cms_pkg::PH_WR_DATA;
               scl_in        = 1'b0;
               sda_in        = req_chan.tx_byte[i2cms_pkg::DataWidth-1];
               tick_in       = i2cms_pkg::load_count(bit_phase_ff);
            end
            i2cms_pkg::FUNC_READ: begin
               ack_choice_in = req_chan.send_ack;
               bit_in        = '0;
               shift_in      = '0;
               phase_in      = i2cms_pkg::PH_RD_LOW;
               scl_in        = 1'b0;
               sda_in        = 1'b1;
               tick_in       = i2cms_pkg::load_count(bit_phase_ff);
            end
            default: ;  // plain tick or unused code: stay idle
         endcase
      end else if (phase_ff != i2cms_pkg::PH_AK_POLL &&
                   phase_ff != i2cms_pkg::PH_AK_CLK && tick_ff != '0) begin
         tick_in = tick_ff - i2cms_pkg::TickWidth'(1);
      end else if (phase_ff == i2cms_pkg::PH_AK_CLK && tick_ff != '0) begin
         tick_in = tick_ff - i2cms_pkg::TickWidth'(1);
      end else begin
         unique case (phase_ff)
            i2cms_pkg::PH_ST_A: begin
               phase_in = i2cms_pkg::PH_ST_B;
               scl_in   = 1'b1;
               sda_in   = 1'b0;
               tick_in  = i2cms_pkg::load_count(start_stop_ff);
            end
            i2cms_pkg::PH_ST_B: begin
               scl_in   = 1'b0;
               phase_in = i2cms_pkg::PH_IDLE;
               tick_in  = '0;
               done_in  = 1'b1;
            end
            i2cms_pkg::PH_SP_A: begin
               phase_in = i2cms_pkg::PH_SP_B;
               scl_in   = 1'b1;
               sda_in   = 1'b0;
               tick_in  = i2cms_pkg::load_count(start_stop_ff);
            end
            i2cms_pkg::PH_SP_B: begin
               sda_in   = 1'b1;
               phase_in = i2cms_pkg::PH_IDLE;
               tick_in  = '0;
               done_in  = 1'b1;
            end
            i2cms_pkg::PH_WR_DATA: begin
               phase_in = i2cms_pkg::PH_WR_HIGH;
               scl_in   = 1'b1;
               tick_in  = i2cms_pkg::load_count(bit_phase_ff);
            end
            i2cms_pkg::PH_WR_HIGH: begin
               phase_in = i2cms_pkg::PH_WR_LOW;
               scl_in   = 1'b0;
               tick_in  = i2cms_pkg::load_count(bit_phase_ff);
            end
            i2cms_pkg::PH_WR_LOW: begin
               bit_in = bit_inc;
               scl_in = 1'b0;
               if (bit_inc < i2cms_pkg::BitsPerByte) begin
                  shift_in = {shift_ff[i2cms_pkg::DataWidth-2:0], 1'b0};
                  phase_in = i2cms_pkg::PH_WR_DATA;
                  sda_in   = shift_ff[i2cms_pkg::DataWidth-1];
                  tick_in  = i2cms_pkg::load_count(bit_phase_ff);
               end else begin
                  // byte out: release SDA for the slave's acknowledge
                  phase_in = i2cms_pkg::PH_AK_REL;
                  sda_in   = 1'b1;
                  tick_in  = '0;
               end
            end
            i2cms_pkg::PH_AK_REL: begin
               phase_in = i2cms_pkg::PH_AK_CLK;
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               tick_in  = '0;
            end
            i2cms_pkg::PH_AK_CLK, i2cms_pkg::PH_AK_POLL: begin
               phase_in = i2cms_pkg::PH_AK_POLL;
               if (!req_chan.sda_in) begin
                  // acknowledged
                  scl_in   = 1'b0;
                  phase_in = i2cms_pkg::PH_IDLE;
                  tick_in  = '0;
                  done_in  = 1'b1;
               end else if (poll_tick >= ack_timeout_ff) begin
                  // timed out: flag it and run a stop condition
                  ack_failed_in = 1'b1;
                  phase_in      = i2cms_pkg::PH_SP_A;
                  scl_in        = 1'b0;
                  sda_in        = 1'b0;
                  tick_in       = i2cms_pkg::load_count(start_stop_ff);
               end else begin
                  tick_in = poll_tick + i2cms_pkg::TickWidth'(1);
               end
            end
            i2cms_pkg::PH_RD_LOW: begin
               phase_in = i2cms_pkg::PH_RD_HIGH;
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               tick_in  = '0;
               shift_in = {shift_ff[i2cms_pkg::DataWidth-2:0], req_chan.sda_in};
               bit_in   = bit_inc;
            end
            i2cms_pkg::PH_RD_HIGH: begin
               scl_in  = 1'b0;
               tick_in = i2cms_pkg::load_count(bit_phase_ff);
               if (bit_ff < i2cms_pkg::BitsPerByte) begin
                  phase_in = i2cms_pkg::PH_RD_LOW;
                  sda_in   = 1'b1;
               end else begin
                  // master ACK pulls SDA low, NACK leaves it released
                  phase_in = i2cms_pkg::PH_RA_SET;
                  sda_in   = !ack_choice_ff;
               end
            end
            i2cms_pkg::PH_RA_SET: begin
               phase_in = i2cms_pkg::PH_RA_HIGH;
               scl_in   = 1'b1;
               tick_in  = i2cms_pkg::load_count(bit_phase_ff);
            end
            i2cms_pkg::PH_RA_HIGH: begin
               scl_in     = 1'b0;
               rx_hold_in = shift_ff;
               phase_in   = i2cms_pkg::PH_IDLE;
               tick_in    = '0;
               done_in    = 1'b1;
            end
            default: begin
               phase_in = i2cms_pkg::PH_IDLE;
               tick_in  = '0;
               done_in  = 1'b1;
            end
         endcase
      end
   end

   // ---- state registers, advanced once per accepted request -------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cms_pkg::PH_IDLE;
         tick_ff       <= '0;
         bit_ff        <= '0;
         shift_ff      <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         ack_choice_ff <= 1'b0;
         ack_failed_ff <= 1'b0;
         rx_hold_ff    <= '0;
      end else if (req_take) begin
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         bit_ff        <= bit_in;
         shift_ff      <= shift_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         ack_choice_ff <= ack_choice_in;
         ack_failed_ff <= ack_failed_in;
         rx_hold_ff    <= rx_hold_in;
      end
   end

   // ---- result register --------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload: no reset needed, qualified by rsp_valid_ff
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_scl_ff    <= scl_in;
         rsp_sda_ff    <= sda_in;
         rsp_busy_ff   <= (phase_in != i2cms_pkg::PH_IDLE);
         rsp_done_ff   <= done_in;
         rsp_rx_ff     <= rx_hold_in;
         rsp_no_ack_ff <= ack_failed_in;
      end
   end

   always_comb begin
      rsp_chan.valid    = rsp_valid_ff;
      rsp_chan.scl_out  = rsp_scl_ff;
      rsp_chan.sda_out  = rsp_sda_ff;
      rsp_chan.busy_res = rsp_busy_ff;
      rsp_chan.done_res = rsp_done_ff;
      rsp_chan.rx_byte  = rsp_rx_ff;
      rsp_chan.no_ack   = rsp_no_ack_ff;
   end

endmodule

[design/i2cms_checker.sv]
// Port-level checks for the I2C master bit sequencer, bound to the top level.
// Depends on i2cms_pkg for widths; sees only the top level's ports.
`timescale 1ns / 1ps

module i2cms_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_scl,
   input logic                              rsp_sda,
   input logic                              rsp_busy,
   input logic                              rsp_done,
   input logic [i2cms_pkg::DataWidth-1:0]   rsp_rx,
   input logic                              rsp_no_ack
);

   // every accepted request yields a pending result on the next edge
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request gave no result");

   // a finishing tick never reports a running sequence
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done) |-> !rsp_busy)
      else $error("done and busy together");

   // no result is pending straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result pending after reset");

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_scl) && $stable(rsp_sda) && $stable(rsp_busy) &&
          $stable(rsp_done) && $stable(rsp_rx) && $stable(rsp_no_ack)))
      else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_scl    (rsp_chan.scl_out),
   .rsp_sda    (rsp_chan.sda_out),
   .rsp_busy   (rsp_chan.busy_res),
   .rsp_done   (rsp_chan.done_res),
   .rsp_rx     (rsp_chan.rx_byte),
   .rsp_no_ack (rsp_chan.no_ack)
);
